### hdl/spi_register_access_master_defines.svh
// Assertion helpers for the SPI register access master.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef SPI_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define SPI_REGISTER_ACCESS_MASTER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define SRAM_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define SRAM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/spi_ram_pkg.sv
package spi_ram_pkg;

    // Frame layout: the full command word is 32 bits, the top FRAME_BITS go out
    localparam int unsigned SHIFT_W        = 32;
    localparam int unsigned FRAME_BITS_DEF = 24;

    localparam int unsigned TICK_W    = 8;
    localparam int unsigned ADDR_W    = 7;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 16;

    // Register reset values
    localparam logic [TICK_W-1:0] SETUP_RST = 8'd40;
    localparam logic [TICK_W-1:0] LEAD_RST  = 8'd7;
    localparam logic [TICK_W-1:0] LOW_RST   = 8'd7;
    localparam logic [TICK_W-1:0] HIGH_RST  = 8'd14;
    localparam logic [TICK_W-1:0] IDLE_RST  = 8'd100;

    // Item kinds carried on tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SETUP = 6'b000010,
        PH_LEAD  = 6'b000100,
        PH_LOW   = 6'b001000,
        PH_HIGH  = 6'b010000,
        PH_TAIL  = 6'b100000
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETUP = 3'd0,
        CFG_LEAD  = 3'd1,
        CFG_LOW   = 3'd2,
        CFG_HIGH  = 3'd3,
        CFG_IDLE  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic cs_n;
        logic sclk;
        logic mosi;
    } pins_t;

    localparam pins_t PINS_IDLE = '{cs_n: 1'b1, sclk: 1'b0, mosi: 1'b0};

endpackage

### hdl/spi_register_access_master.sv
// SPI register access master for single-byte register reads and writes, with
// pin timing driven by tick items. A start item (tuser 0) loads the frame
// (read flag, 7-bit address, data byte) and a tick item (tuser 1) advances
// the timing by one step and returns the pin levels for that tick. Each item
// yields exactly one result. The block takes one item per clock cycle while
// m_tready does not hold a waiting result: an input register and a result
// register enclose one pass of next-state logic, the result register offers
// each result and lets the next item enter while a result waits. Sequence per
// transaction: setup (cs_n high), lead (cs_n low), FRAME_BITS bits of
// low/high sclk with miso sampled on the last high tick, then a tail with
// cs_n high before done. Users write timing registers through the cfg port
// while no transaction is running (unenforced); a start while busy is refused.
`include "spi_register_access_master_defines.svh"

module spi_register_access_master #(
    parameter int unsigned FRAME_BITS = spi_ram_pkg::FRAME_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input transactions
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [0] is_read, [7:1] address, [15:8] write_data, [16] miso, [23:17] zero
    input  logic [spi_ram_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] kind
    input  logic [0:0]                            s_tuser,
    // result transactions
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] cs_n, [1] sclk, [2] mosi, [3] busy_res, [4] done_res,
    // [12:5] read_data, [13] refused, [15:14] zero
    output logic [spi_ram_pkg::M_TDATA_W-1:0]     m_tdata,
    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spi_ram_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spi_ram_pkg::TICK_W-1:0]        cfg_data
);
    import spi_ram_pkg::*;

    localparam int unsigned BIT_CNT_W = $clog2(FRAME_BITS + 1);

    // Configuration registers
    logic [TICK_W-1:0] setup_ticks_reg, lead_ticks_reg, low_ticks_reg;
    logic [TICK_W-1:0] high_ticks_reg, idle_ticks_reg;

    // Input stage
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic              in_is_read_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [BYTE_W-1:0] in_wdata_reg;
    logic              in_miso_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [BIT_CNT_W-1:0]  bit_count_reg, bit_count_next, bit_inc;
    logic [FRAME_BITS-1:0] out_shift_reg, out_shift_next;
    logic [BYTE_W-1:0]     in_shift_reg, in_shift_next;
    pins_t                 pin_levels_reg, pins;

    // Per-item results
    logic              refused, done;
    logic [BYTE_W-1:0] read_data;
    logic              busy;

    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic              advance;
    logic [TICK_W:0]   tick_inc;
    logic [TICK_W-1:0] len;
    logic [SHIFT_W-1:0] frame;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Take register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_ticks_reg <= SETUP_RST;
            lead_ticks_reg  <= LEAD_RST;
            low_ticks_reg   <= LOW_RST;
            high_ticks_reg  <= HIGH_RST;
            idle_ticks_reg  <= IDLE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SETUP: setup_ticks_reg <= cfg_data;
                CFG_LEAD:  lead_ticks_reg  <= cfg_data;
                CFG_LOW:   low_ticks_reg   <= cfg_data;
                CFG_HIGH:  high_ticks_reg  <= cfg_data;
                CFG_IDLE:  idle_ticks_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Capture input transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg    <= s_tuser[0];
            in_is_read_reg <= s_tdata[0];
            in_addr_reg    <= s_tdata[ADDR_W:1];
            in_wdata_reg   <= s_tdata[ADDR_W+BYTE_W:ADDR_W+1];
            in_miso_reg    <= s_tdata[ADDR_W+BYTE_W+1];
        end
    end

    // Length of the current phase; low and high last at least one tick
    always_comb begin
        unique case (phase_reg)
            PH_SETUP: len = setup_ticks_reg;
            PH_LEAD:  len = lead_ticks_reg;
            PH_LOW:   len = (low_ticks_reg == '0) ? TICK_W'(1) : low_ticks_reg;
            PH_HIGH:  len = (high_ticks_reg == '0) ? TICK_W'(1) : high_ticks_reg;
            PH_TAIL:  len = idle_ticks_reg;
            default:  len = TICK_W'(1);
        endcase
    end

    assign tick_inc = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign bit_inc  = bit_count_reg + BIT_CNT_W'(1);
    assign frame    = {in_is_read_reg, 8'h00, in_addr_reg, in_wdata_reg, 8'h00};

    // Sequencer next state and pin levels
    always_comb begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bit_count_next = bit_count_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;
        pins           = PINS_IDLE;
        refused        = 1'b0;
        done           = 1'b0;

        if (in_kind_reg == KIND_START) begin
            if (phase_reg == PH_IDLE) begin
                // Load the frame and skip empty setup and lead phases
                out_shift_next = frame[SHIFT_W-1 -: FRAME_BITS];
                in_shift_next  = '0;
                bit_count_next = '0;
                tick_next      = '0;
                if (setup_ticks_reg != '0) begin
                    phase_next = PH_SETUP;
                end else if (lead_ticks_reg != '0) begin
                    phase_next = PH_LEAD;
                end else begin
                    phase_next = PH_LOW;
                end
            end else begin
                pins    = pin_levels_reg;
                refused = 1'b1;
            end
        end else begin
            // Drive pins for the current phase
            unique case (phase_reg)
                PH_LEAD: pins = '{cs_n: 1'b0, sclk: 1'b0, mosi: 1'b0};
                PH_LOW:  pins = '{cs_n: 1'b0, sclk: 1'b0,
                                  mosi: out_shift_reg[FRAME_BITS-1]};
                PH_HIGH: pins = '{cs_n: 1'b0, sclk: 1'b1,
                                  mosi: out_shift_reg[FRAME_BITS-1]};
                default: pins = PINS_IDLE;
            endcase

            if (phase_reg != PH_IDLE) begin
                tick_next = tick_inc[TICK_W-1:0];
                if (tick_inc >= {1'b0, len}) begin
                    tick_next = '0;
                    unique case (phase_reg)
                        PH_SETUP: begin
                            phase_next = (lead_ticks_reg != '0) ? PH_LEAD : PH_LOW;
                        end
                        PH_LEAD: begin
                            phase_next = PH_LOW;
                        end
                        PH_LOW: begin
                            phase_next = PH_HIGH;
                        end
                        PH_HIGH: begin
                            // Sample miso, advance the frame by one bit
                            in_shift_next  = {in_shift_reg[BYTE_W-2:0], in_miso_reg};
                            out_shift_next = {out_shift_reg[FRAME_BITS-2:0], 1'b0};
                            bit_count_next = bit_inc;
                            if (bit_inc == BIT_CNT_W'(FRAME_BITS)) begin
                                if (idle_ticks_reg != '0) begin
                                    phase_next = PH_TAIL;
                                end else begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                end
                            end else begin
                                phase_next = PH_LOW;
                            end
                        end
                        PH_TAIL: begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end

        busy      = (phase_next != PH_IDLE);
        read_data = done ? in_shift_next : '0;
    end

    // Commit sequencer state as each item passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bit_count_reg  <= '0;
            out_shift_reg  <= '0;
            in_shift_reg   <= '0;
            pin_levels_reg <= PINS_IDLE;
        end else if (advance) begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_count_reg  <= bit_count_next;
            out_shift_reg  <= out_shift_next;
            in_shift_reg   <= in_shift_next;
            pin_levels_reg <= pins;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, refused, read_data, done, busy,
                             pins.mosi, pins.sclk, pins.cs_n};
        end
    end

    // Checks
    `SRAM_ASSERT_SAME(a_refused_busy, out_valid_reg && out_data_reg[13], out_data_reg[3],
        "refused start reported while not busy")
    `SRAM_ASSERT_SAME(a_done_not_busy, out_valid_reg && out_data_reg[4], !out_data_reg[3],
        "done reported while still busy")
    `SRAM_ASSERT_SAME(a_bit_count_bound, 1'b1, bit_count_reg <= BIT_CNT_W'(FRAME_BITS),
        "bit count ran past the frame length")
    `SRAM_ASSERT_NEXT(a_start_goes_busy,
        advance && in_kind_reg == KIND_START && phase_reg == PH_IDLE,
        phase_reg != PH_IDLE, "accepted start did not leave idle")

endmodule
